// ===== design/vlcbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlcbp_pkg
// shared constants and codes for the variable-length code bit packer
// ----------------------------------------------------------------------------
package vlcbp_pkg;

   localparam int CODE_WIDTH_DEF = 128;  // default code width in bits
   localparam int HALF_W         = 64;   // width of each code half on the port
   localparam int CODE_LEN_W     = 8;    // width of the code length field
   localparam int BYTE_W         = 8;
   localparam int QUEUE_DEPTH    = 2;    // entries between front and back

   typedef enum logic {
      CMD_APPEND = 1'b0,
      CMD_FLUSH  = 1'b1
   } command_type;

endpackage

`default_nettype wire

// ===== design/vlcbp_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlcbp_req_if / vlcbp_rsp_if
// valid/ready channels for code items in and packed bytes out
// ----------------------------------------------------------------------------
interface vlcbp_req_if import vlcbp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  command;
   logic [HALF_W-1:0]     code_high;
   logic [HALF_W-1:0]     code_low;
   logic [CODE_LEN_W-1:0] code_len;

   modport source (output valid, command, code_high, code_low, code_len, input ready);
   modport sink   (input valid, command, code_high, code_low, code_len, output ready);
endinterface

interface vlcbp_rsp_if import vlcbp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last;

   modport source (output valid, out_byte, last, input ready);
   modport sink   (input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

// ===== design/variable_length_code_bit_packer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// variable_length_code_bit_packer_top
// msb-first packer of variable-length codes into a byte stream
// ----------------------------------------------------------------------------
// Each append transfer carries a code of up to CODE_WIDTH bits, right-aligned
// across code_high and code_low, and its length; the low code_len bits are
// packed most significant first behind any bits still pending from earlier
// codes, and every byte that fills up leaves on the rsp channel with the first
// packed bit in bit 7. A length above CODE_WIDTH counts as CODE_WIDTH, and a
// length of zero changes nothing. A flush transfer sends the pending partial
// byte, zero padded, if any bits are pending, and clears it. The last byte
// caused by an input transfer carries last. Timing: the front clamps and
// aligns the code in the accept cycle and writes it to a two-entry queue, so
// req_ready only drops when two items wait. The back takes an item in its idle
// state and then drains one byte per cycle into the output register while the
// output is not stalled, so an append that yields whole bytes holds the back in
// the drain state until its last byte is registered and takes no new item
// before then; a flush or an append that completes no byte never enters the
// drain state. rsp_ready low stalls the drain without losing data.
// ----------------------------------------------------------------------------
module variable_length_code_bit_packer_top import vlcbp_pkg::*; #(
   parameter int CODE_WIDTH = CODE_WIDTH_DEF
) (
   input  wire          clock,
   input  wire          reset,
   vlcbp_req_if.sink    req_ch,
   vlcbp_rsp_if.source  rsp_ch
);

   localparam int LEN_W  = $clog2(CODE_WIDTH + 1);
   localparam int DATA_W = 1 + LEN_W + CODE_WIDTH;

   // front to queue
   logic                  push;
   logic                  queue_full;
   command_type           entry_cmd;
   logic [LEN_W-1:0]      entry_len;
   logic [CODE_WIDTH-1:0] entry_code;

   // queue to back
   logic                  q_valid;
   logic                  q_pop;
   logic [DATA_W-1:0]     head_data;
   command_type           q_cmd;
   logic [LEN_W-1:0]      q_len;
   logic [CODE_WIDTH-1:0] q_code;

   // front: clamp length, left-align code
   vlcbp_front #(
      .CODE_WIDTH (CODE_WIDTH),
      .LEN_W      (LEN_W)
   ) u_front (
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .entry_cmd  (entry_cmd),
      .entry_len  (entry_len),
      .entry_code (entry_code)
   );

   // decoupling queue, lets an input transfer land while bytes drain
   vlcbp_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({entry_cmd, entry_len, entry_code}),
      .full      (queue_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_data (head_data)
   );

   assign q_cmd  = command_type'(head_data[DATA_W-1]);
   assign q_len  = head_data[CODE_WIDTH +: LEN_W];
   assign q_code = head_data[CODE_WIDTH-1:0];

   // back: merge with partial byte, one byte per cycle out while not stalled
   vlcbp_back #(
      .CODE_WIDTH (CODE_WIDTH),
      .LEN_W      (LEN_W)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (q_cmd),
      .q_len   (q_len),
      .q_code  (q_code),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== design/vlcbp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlcbp_front
// accepts code items, clamps the length and left-aligns the code
// ----------------------------------------------------------------------------
module vlcbp_front import vlcbp_pkg::*; #(
   parameter int CODE_WIDTH = CODE_WIDTH_DEF,
   parameter int LEN_W      = $clog2(CODE_WIDTH + 1)
) (
   vlcbp_req_if.sink        req_ch,
   input  logic             queue_full,
   output logic             push,
   output command_type      entry_cmd,
   output logic [LEN_W-1:0] entry_len,
   output logic [CODE_WIDTH-1:0] entry_code
);

   logic [2*HALF_W-1:0]   code_full;
   logic [CODE_WIDTH-1:0] code_w;
   logic [LEN_W-1:0]      len_clamped;
   logic [LEN_W-1:0]      shamt;

   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;
   assign entry_cmd    = command_type'(req_ch.command);

   assign code_full = {req_ch.code_high, req_ch.code_low};
   assign code_w    = code_full[CODE_WIDTH-1:0];

   always_comb begin
      if (req_ch.code_len > CODE_LEN_W'(CODE_WIDTH)) begin
         len_clamped = LEN_W'(CODE_WIDTH);
      end else begin
         len_clamped = req_ch.code_len[LEN_W-1:0];
      end
   end

   // shifting left drops everything above the length, first bit lands on top
   assign shamt      = LEN_W'(CODE_WIDTH) - len_clamped;
   assign entry_len  = len_clamped;
   assign entry_code = code_w << shamt;

endmodule

`default_nettype wire

// ===== design/vlcbp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlcbp_queue
// short register queue between the front and the back
// ----------------------------------------------------------------------------
module vlcbp_queue import vlcbp_pkg::*; #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output logic [DATA_W-1:0] head_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/vlcbp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlcbp_back
// merges queued codes with the partial byte and drains whole bytes
// ----------------------------------------------------------------------------
module vlcbp_back import vlcbp_pkg::*; #(
   parameter int CODE_WIDTH = CODE_WIDTH_DEF,
   parameter int LEN_W      = $clog2(CODE_WIDTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  command_type           q_cmd,
   input  logic [LEN_W-1:0]      q_len,
   input  logic [CODE_WIDTH-1:0] q_code,
   output logic                  q_pop,
   vlcbp_rsp_if.source           rsp_ch
);

   localparam int STREAM_W = CODE_WIDTH + BYTE_W;
   localparam int TOT_W    = $clog2(CODE_WIDTH + BYTE_W);
   localparam int CNT_W    = TOT_W - 3;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   state_type           state_ff, state_in;
   logic [STREAM_W-1:0] stream_ff, stream_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic [2:0]          rem_ff, rem_in;
   logic [BYTE_W-1:0]   pend_bits_ff, pend_bits_in;
   logic [2:0]          pend_cnt_ff, pend_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free;
   logic [STREAM_W-1:0] merged;
   logic [TOT_W-1:0]    total;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign q_pop    = (state_ff == ST_IDLE) && q_valid && out_free;

   // pending bits on top, code bits right behind them
   assign merged = {pend_bits_ff, {CODE_WIDTH{1'b0}}}
                 | ({q_code, {BYTE_W{1'b0}}} >> pend_cnt_ff);
   assign total  = TOT_W'(pend_cnt_ff) + TOT_W'(q_len);

   always_comb begin
      state_in     = state_ff;
      stream_in    = stream_ff;
      left_in      = left_ff;
      rem_in       = rem_ff;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               if (q_cmd == CMD_FLUSH) begin
                  if (pend_cnt_ff != '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_byte_in  = pend_bits_ff;
                     rsp_last_in  = 1'b1;
                  end
                  pend_bits_in = '0;
                  pend_cnt_in  = '0;
               end else if (total[TOT_W-1:3] == '0) begin
                  // not enough for a byte, just grow the partial byte
                  pend_bits_in = merged[STREAM_W-1 -: BYTE_W];
                  pend_cnt_in  = total[2:0];
               end else begin
                  stream_in = merged;
                  left_in   = total[TOT_W-1:3];
                  rem_in    = total[2:0];
                  state_in  = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = stream_ff[STREAM_W-1 -: BYTE_W];
               rsp_last_in  = (left_ff == CNT_W'(1));
               stream_in    = stream_ff << BYTE_W;
               left_in      = left_ff - CNT_W'(1);
               if (left_ff == CNT_W'(1)) begin
                  // leftover bits sit just below the byte going out
                  pend_bits_in = stream_ff[CODE_WIDTH-1 -: BYTE_W];
                  pend_cnt_in  = rem_ff;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      stream_ff   <= stream_in;
      left_ff     <= left_in;
      rem_ff      <= rem_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_byte = rsp_byte_ff;
   assign rsp_ch.last     = rsp_last_ff;

endmodule

`default_nettype wire

// ===== design/vlcbp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlcbp_checker
// port-level checks on the packed byte channel
// ----------------------------------------------------------------------------
module vlcbp_checker import vlcbp_pkg::*; (
   input wire              clock,
   input wire              reset,
   input wire              rsp_valid,
   input wire              rsp_ready,
   input wire [BYTE_W-1:0] rsp_out_byte,
   input wire              rsp_last
);

   // stalled byte stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // stalled byte does not change
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("rsp payload changed while stalled");

   // nothing offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // bytes of one code leave without gaps once the first is taken
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside a multi-byte result");

endmodule

bind variable_length_code_bit_packer_top vlcbp_checker u_vlcbp_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_out_byte (rsp_ch.out_byte),
   .rsp_last     (rsp_ch.last)
);

`default_nettype wire
